@@ hw/rtl/rlbcd_pkg.sv @@
package rlbcd_pkg;

    localparam int DEFAULT_NUM_ENTRIES = 32;

    localparam int DEV_W     = 16;
    localparam int BLK_W     = 32;
    localparam int IDX_W     = 5;
    localparam int TIME_W    = 31;
    localparam int COUNT_W   = 8;
    localparam int ENTRY_W   = 8;   // wide enough for any entry number up to 255
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_COUNT  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_HIT_INC,
        CMD_RETAG,
        CMD_PIN_INC,
        CMD_DEC,
        CMD_DEC_STAMP
    } cmd_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_RESOLVE
    } fsm_t;

    typedef struct packed {
        op_t               op;
        logic [DEV_W-1:0]  device;
        logic [BLK_W-1:0]  block_number;
        logic [IDX_W-1:0]  entry_index;
        logic [TIME_W-1:0] now_ticks;
    } req_t;

    // Running search result handed from cell to cell
    typedef struct packed {
        logic               hit_found;
        logic [ENTRY_W-1:0] hit_idx;
        logic [COUNT_W-1:0] hit_count;
        logic               hit_valid;
        logic               free_found;
        logic [ENTRY_W-1:0] free_idx;
        logic [TIME_W-1:0]  free_time;
        logic [COUNT_W-1:0] tgt_count;
    } scan_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [ENTRY_W-1:0] entry;
    } commit_t;

endpackage

@@ hw/rtl/rlbcd_cell.sv @@
module rlbcd_cell #(
    parameter logic [rlbcd_pkg::ENTRY_W-1:0] CELL_IDX = '0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  rlbcd_pkg::req_t    req,
    input  rlbcd_pkg::scan_t   carry_in,
    output rlbcd_pkg::scan_t   carry_out,
    input  rlbcd_pkg::commit_t commit
);

    logic [rlbcd_pkg::DEV_W-1:0]   dev_reg,   dev_next;
    logic [rlbcd_pkg::BLK_W-1:0]   blk_reg,   blk_next;
    logic [rlbcd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [rlbcd_pkg::TIME_W-1:0]  rtime_reg, rtime_next;
    logic                          valid_reg, valid_next;
    rlbcd_pkg::scan_t              carry_reg, carry_next;

    logic tag_match;
    logic idx_match;
    logic mine;

    assign tag_match = (dev_reg == req.device) && (blk_reg == req.block_number);
    assign idx_match = ({{(rlbcd_pkg::ENTRY_W-rlbcd_pkg::IDX_W){1'b0}}, req.entry_index}
                        == CELL_IDX);
    assign mine      = (commit.entry == CELL_IDX);

    // Fold this entry into the running search
    always_comb begin
        carry_next = carry_in;
        if (!carry_in.hit_found && tag_match) begin
            carry_next.hit_found = 1'b1;
            carry_next.hit_idx   = CELL_IDX;
            carry_next.hit_count = count_reg;
            carry_next.hit_valid = valid_reg;
        end
        if ((count_reg == '0) && (!carry_in.free_found || (rtime_reg < carry_in.free_time))) begin
            carry_next.free_found = 1'b1;
            carry_next.free_idx   = CELL_IDX;
            carry_next.free_time  = rtime_reg;
        end
        if (idx_match) begin
            carry_next.tgt_count = count_reg;
        end
    end

    // Apply the commit addressed to this entry
    always_comb begin
        dev_next   = dev_reg;
        blk_next   = blk_reg;
        count_next = count_reg;
        rtime_next = rtime_reg;
        valid_next = valid_reg;
        if (mine) begin
            case (commit.cmd)
                rlbcd_pkg::CMD_HIT_INC: begin
                    count_next = count_reg + rlbcd_pkg::COUNT_W'(1);
                    valid_next = 1'b1;
                end
                rlbcd_pkg::CMD_RETAG: begin
                    dev_next   = req.device;
                    blk_next   = req.block_number;
                    count_next = {{(rlbcd_pkg::COUNT_W-1){1'b0}}, 1'b1};
                    valid_next = 1'b1;
                end
                rlbcd_pkg::CMD_PIN_INC: begin
                    count_next = count_reg + rlbcd_pkg::COUNT_W'(1);
                end
                rlbcd_pkg::CMD_DEC: begin
                    count_next = count_reg - rlbcd_pkg::COUNT_W'(1);
                end
                rlbcd_pkg::CMD_DEC_STAMP: begin
                    count_next = count_reg - rlbcd_pkg::COUNT_W'(1);
                    rtime_next = req.now_ticks;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_reg   <= '0;
            blk_reg   <= '0;
            count_reg <= '0;
            rtime_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            dev_reg   <= dev_next;
            blk_reg   <= blk_next;
            count_reg <= count_next;
            rtime_reg <= rtime_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        carry_reg <= carry_next;
    end

    assign carry_out = carry_reg;

endmodule

@@ hw/rtl/refcounted_lru_block_cache_directory.sv @@
// Operation: an item is accepted in idle, then the scan state walks the search down the
// chain of entry cells one cell per cycle, then the resolve state decides the result,
// loads the output register and commits the update; resolve waits while the output is
// full and not taken. A new item is accepted only in idle, after the last one resolves.
// Reset (aresetn low, synchronous): all tags, counts, release times and valid bits
// clear to zero; the controller returns to idle and the output holds no item.
module refcounted_lru_block_cache_directory #(
    parameter int NUM_ENTRIES = rlbcd_pkg::DEFAULT_NUM_ENTRIES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: operation[1:0], device[17:2], block_number[49:18],
    //          entry_index[54:50], now_ticks[85:55], zero fill[87:86]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rlbcd_pkg::IN_DATA_W-1:0]     s_tdata,
    // m_tdata: result_entry[4:0], was_hit[5], needs_read[6], status[8:7],
    //          zero fill[15:9]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rlbcd_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int CNT_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    rlbcd_pkg::fsm_t    state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    rlbcd_pkg::req_t    req_reg;
    rlbcd_pkg::commit_t commit;
    rlbcd_pkg::scan_t   carry [NUM_ENTRIES];
    rlbcd_pkg::scan_t   last;

    logic                         s_fire;
    logic                         resolve_fire;
    logic                         scan_done;

    // result of the resolve step
    logic [rlbcd_pkg::IDX_W-1:0]    res_entry;
    logic                           res_hit;
    logic                           res_read;
    rlbcd_pkg::status_t             res_status;
    rlbcd_pkg::cmd_t                res_cmd;
    logic [rlbcd_pkg::ENTRY_W-1:0]  res_cmd_entry;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic [rlbcd_pkg::IDX_W-1:0]    out_entry_reg;
    logic                           out_hit_reg;
    logic                           out_read_reg;
    logic [1:0]                     out_status_reg;

    assign s_fire    = s_tvalid && s_tready;
    assign scan_done = (cnt_reg == CNT_W'(NUM_ENTRIES - 1));
    assign last      = carry[NUM_ENTRIES-1];

    // Hold the request for the whole scan; only idle takes a new item
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg.op           <= rlbcd_pkg::op_t'(s_tdata[1:0]);
            req_reg.device       <= s_tdata[17:2];
            req_reg.block_number <= s_tdata[49:18];
            req_reg.entry_index  <= s_tdata[54:50];
            req_reg.now_ticks    <= s_tdata[85:55];
        end
    end

    // Chain of entry cells; the search result ripples one cell per cycle
    genvar gi;
    generate
        for (gi = 0; gi < NUM_ENTRIES; gi++) begin : g_cell
            rlbcd_pkg::scan_t cin;
            if (gi == 0) begin : g_head
                assign cin = '0;
            end else begin : g_body
                assign cin = carry[gi-1];
            end
            rlbcd_cell #(
                .CELL_IDX (rlbcd_pkg::ENTRY_W'(gi))
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .req       (req_reg),
                .carry_in  (cin),
                .carry_out (carry[gi]),
                .commit    (commit)
            );
        end
    endgenerate

    // Decide the result and the update from what the scan collected
    always_comb begin
        res_entry     = '0;
        res_hit       = 1'b0;
        res_read      = 1'b0;
        res_status    = rlbcd_pkg::ST_OK;
        res_cmd       = rlbcd_pkg::CMD_NONE;
        res_cmd_entry = '0;
        if (req_reg.op == rlbcd_pkg::OP_GET) begin
            if (last.hit_found) begin
                res_entry     = last.hit_idx[rlbcd_pkg::IDX_W-1:0];
                res_hit       = 1'b1;
                res_cmd_entry = last.hit_idx;
                if (last.hit_count == rlbcd_pkg::COUNT_MAX) begin
                    // count would overflow: report it, change nothing
                    res_status = rlbcd_pkg::ST_COUNT;
                end else begin
                    res_read = !last.hit_valid;
                    res_cmd  = rlbcd_pkg::CMD_HIT_INC;
                end
            end else if (last.free_found) begin
                res_entry     = last.free_idx[rlbcd_pkg::IDX_W-1:0];
                res_read      = 1'b1;
                res_cmd       = rlbcd_pkg::CMD_RETAG;
                res_cmd_entry = last.free_idx;
            end else begin
                res_status = rlbcd_pkg::ST_NOFREE;
            end
        end else begin
            res_entry     = req_reg.entry_index;
            res_cmd_entry = {{(rlbcd_pkg::ENTRY_W-rlbcd_pkg::IDX_W){1'b0}},
                             req_reg.entry_index};
            if (int'(req_reg.entry_index) >= NUM_ENTRIES) begin
                res_status = rlbcd_pkg::ST_COUNT;
            end else if (req_reg.op == rlbcd_pkg::OP_PIN) begin
                if (last.tgt_count == rlbcd_pkg::COUNT_MAX) begin
                    res_status = rlbcd_pkg::ST_COUNT;
                end else begin
                    res_cmd = rlbcd_pkg::CMD_PIN_INC;
                end
            end else if (last.tgt_count == '0) begin
                // underflow on release or unpin
                res_status = rlbcd_pkg::ST_COUNT;
            end else if ((req_reg.op == rlbcd_pkg::OP_RELEASE) &&
                         (last.tgt_count == {{(rlbcd_pkg::COUNT_W-1){1'b0}}, 1'b1})) begin
                // final release: stamp the time
                res_cmd = rlbcd_pkg::CMD_DEC_STAMP;
            end else begin
                res_cmd = rlbcd_pkg::CMD_DEC;
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rlbcd_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = rlbcd_pkg::FSM_SCAN;
                end
            end
            rlbcd_pkg::FSM_SCAN: begin
                if (scan_done) begin
                    state_next = rlbcd_pkg::FSM_RESOLVE;
                end
            end
            rlbcd_pkg::FSM_RESOLVE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = rlbcd_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = rlbcd_pkg::FSM_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_tready     = 1'b0;
        resolve_fire = 1'b0;
        cnt_next     = '0;
        unique case (state_reg)
            rlbcd_pkg::FSM_IDLE: begin
                s_tready = 1'b1;
            end
            rlbcd_pkg::FSM_SCAN: begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            rlbcd_pkg::FSM_RESOLVE: begin
                resolve_fire = !m_valid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    // Commit the update to the cells on the same edge that loads the output
    always_comb begin
        commit.cmd   = resolve_fire ? res_cmd : rlbcd_pkg::CMD_NONE;
        commit.entry = res_cmd_entry;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (resolve_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rlbcd_pkg::FSM_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (resolve_fire) begin
            out_entry_reg  <= res_entry;
            out_hit_reg    <= res_hit;
            out_read_reg   <= res_read;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, out_status_reg, out_read_reg, out_hit_reg, out_entry_reg};

endmodule

@@ verif/tb_refcounted_lru_block_cache_directory.sv @@
module tb_refcounted_lru_block_cache_directory;

    localparam int NUM_ENTRIES  = 32;
    localparam int RANDOM_ITEMS = 1250;
    // Allow for the block's scan of every entry per item, slow idling phases
    // and a full count sweep, then take that several times over.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = NUM_ENTRIES + 8;

    // One request as queued for the driver, with its predicted response attached.
    typedef struct {
        logic [4:0]           entry;
        bit                   hit;
        bit                   read;
        rlbcd_pkg::status_t   status;
    } dir_resp_t;

    typedef struct {
        rlbcd_pkg::op_t op;
        logic [15:0]    device;
        logic [31:0]    block_number;
        logic [4:0]     entry_index;
        logic [30:0]    now_ticks;
        bit             drain_first;   // hold until every awaited response is back
        int unsigned    phase;         // idling phase for this item
        dir_resp_t      resp;
    } dir_req_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    // s_tdata: operation, device, block_number, entry_index, now_ticks, zero fill
    logic [rlbcd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    // m_tdata: result_entry, was_hit, needs_read, status, zero fill
    logic [rlbcd_pkg::OUT_DATA_W-1:0] m_tdata;

    // Shadow copy of the directory, advanced as requests are generated.
    logic [15:0] shadow_dev   [NUM_ENTRIES];
    logic [31:0] shadow_blk   [NUM_ENTRIES];
    int unsigned shadow_refs  [NUM_ENTRIES];
    logic [30:0] shadow_stamp [NUM_ENTRIES];
    bit          shadow_valid [NUM_ENTRIES];

    dir_req_t    dir_requests[$];
    dir_resp_t   awaited_results[$];
    dir_req_t    cur_req;
    bit          have_req = 1'b0;
    bit          req_shown = 1'b0;
    bit          req_taken = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned generated = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    refcounted_lru_block_cache_directory #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Apply one request to the shadow directory and return the response it earns.
    function automatic dir_resp_t apply_directory_op(rlbcd_pkg::op_t op, logic [15:0] dev,
                                                     logic [31:0] blk, logic [4:0] idx,
                                                     logic [30:0] now);
        dir_resp_t   r;
        int          hit_at;
        int          victim;
        logic [30:0] oldest;
        r.entry  = '0;
        r.hit    = 1'b0;
        r.read   = 1'b0;
        r.status = rlbcd_pkg::ST_OK;
        oldest   = '0;
        if (op == rlbcd_pkg::OP_GET) begin
            // lowest matching index wins, reset tags (0,0) included
            hit_at = -1;
            for (int i = 0; i < NUM_ENTRIES; i++)
                if (hit_at < 0 && shadow_dev[i] == dev && shadow_blk[i] == blk)
                    hit_at = i;
            if (hit_at >= 0) begin
                r.entry = 5'(hit_at);
                r.hit   = 1'b1;
                if (shadow_refs[hit_at] >= 255) begin
                    r.status = rlbcd_pkg::ST_COUNT;
                end else begin
                    shadow_refs[hit_at]++;
                    r.read = !shadow_valid[hit_at];
                    shadow_valid[hit_at] = 1'b1;
                end
            end else begin
                // oldest unreferenced entry, ties to the lowest index
                victim = -1;
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (shadow_refs[i] == 0 && (victim < 0 || shadow_stamp[i] < oldest)) begin
                        victim = i;
                        oldest = shadow_stamp[i];
                    end
                if (victim < 0) begin
                    r.status = rlbcd_pkg::ST_NOFREE;
                end else begin
                    shadow_dev[victim]   = dev;
                    shadow_blk[victim]   = blk;
                    shadow_refs[victim]  = 1;
                    shadow_valid[victim] = 1'b1;
                    r.entry = 5'(victim);
                    r.read  = 1'b1;
                end
            end
        end else begin
            r.entry = idx;
            if (op == rlbcd_pkg::OP_PIN) begin
                if (shadow_refs[idx] >= 255) r.status = rlbcd_pkg::ST_COUNT;
                else shadow_refs[idx]++;
            end else if (shadow_refs[idx] == 0) begin
                r.status = rlbcd_pkg::ST_COUNT;
            end else begin
                shadow_refs[idx]--;
                // only a release stamps the time, an unpin to zero does not
                if (op == rlbcd_pkg::OP_RELEASE && shadow_refs[idx] == 0)
                    shadow_stamp[idx] = now;
            end
        end
        return r;
    endfunction

    // Predict the response and queue the request for the driver.
    task automatic add_req(rlbcd_pkg::op_t op, logic [15:0] dev, logic [31:0] blk,
                           logic [4:0] idx, logic [30:0] now, bit drain);
        dir_req_t q;
        q.op           = op;
        q.device       = dev;
        q.block_number = blk;
        q.entry_index  = idx;
        q.now_ticks    = now;
        q.drain_first  = drain;
        q.phase        = (generated / 90) % 4;
        q.resp         = apply_directory_op(op, dev, blk, idx, now);
        dir_requests.push_back(q);
        generated++;
    endtask

    // Small stamps make age ties likely; wide ones toggle every bit.
    function automatic logic [30:0] rand_now();
        if ($urandom_range(0, 1) == 0) return 31'($urandom_range(0, 3));
        return 31'($urandom);
    endfunction

    function automatic int pick_held();
        int held[$];
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (shadow_refs[i] > 0) held.push_back(i);
        if (held.size() == 0) return -1;
        return held[$urandom_range(0, held.size() - 1)];
    endfunction

    function automatic bit any_free();
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (shadow_refs[i] == 0) return 1'b1;
        return 1'b0;
    endfunction

    function automatic rlbcd_pkg::op_t drop_op();
        if ($urandom_range(0, 3) == 0) return rlbcd_pkg::OP_UNPIN;
        return rlbcd_pkg::OP_RELEASE;
    endfunction

    // Grab every entry with fresh tags, overrun into no-free, then release everything.
    task automatic fill_and_drain();
        int guard;
        int start;
        int e;
        add_req(rlbcd_pkg::OP_GET, 16'($urandom), $urandom, 5'($urandom), rand_now(), 1'b1);
        guard = 0;
        while (any_free() && guard < 40) begin
            add_req(rlbcd_pkg::OP_GET, 16'($urandom), $urandom, 5'($urandom), rand_now(),
                    1'b0);
            guard++;
        end
        repeat ($urandom_range(1, 2))
            add_req(rlbcd_pkg::OP_GET, 16'($urandom), $urandom, 5'($urandom), rand_now(),
                    1'b0);
        start = $urandom_range(0, NUM_ENTRIES - 1);
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            e = (k + start) % NUM_ENTRIES;
            while (shadow_refs[e] > 0)
                add_req(drop_op(), 16'($urandom), $urandom, 5'(e), rand_now(), 1'b0);
        end
    endtask

    // Drive one entry to the count ceiling, overflow it by pin and by get, walk it back.
    task automatic saturate_entry();
        int          e;
        int          h;
        int unsigned base;
        e = $urandom_range(0, NUM_ENTRIES - 1);
        h = e;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
            if (shadow_dev[i] == shadow_dev[e] && shadow_blk[i] == shadow_blk[e]) h = i;
        base = shadow_refs[h];
        while (shadow_refs[h] < 255)
            add_req(rlbcd_pkg::OP_PIN, 16'($urandom), $urandom, 5'(h), rand_now(), 1'b0);
        repeat (2)
            add_req(rlbcd_pkg::OP_PIN, 16'($urandom), $urandom, 5'(h), rand_now(), 1'b0);
        add_req(rlbcd_pkg::OP_GET, shadow_dev[h], shadow_blk[h], 5'($urandom), rand_now(),
                1'b0);
        while (shadow_refs[h] > base)
            add_req(drop_op(), 16'($urandom), $urandom, 5'(h), rand_now(), 1'b0);
    endtask

    // Mostly gets on a small tag pool and drops of held entries, with some noise.
    task automatic mixed_traffic();
        int r;
        int e;
        repeat (24) begin
            r = $urandom_range(0, 99);
            e = pick_held();
            if (r < 38 || (r < 75 && e < 0)) begin
                add_req(rlbcd_pkg::OP_GET, 16'($urandom_range(0, 3)),
                        32'($urandom_range(0, 11)), 5'($urandom), rand_now(), 1'b0);
            end else if (r < 75) begin
                add_req(drop_op(), 16'($urandom), $urandom, 5'(e), rand_now(), 1'b0);
            end else if (r < 80) begin
                add_req(rlbcd_pkg::OP_PIN, 16'($urandom), $urandom, 5'($urandom),
                        rand_now(), 1'b0);
            end else if (r < 88) begin
                add_req(rlbcd_pkg::OP_GET, 16'($urandom), $urandom, 5'($urandom),
                        rand_now(), 1'b0);
            end else begin
                // any count op on any entry, underflows included
                add_req(rlbcd_pkg::op_t'($urandom_range(1, 3)), 16'($urandom), $urandom,
                        5'($urandom), rand_now(), 1'b0);
            end
        end
    endtask

    initial begin : stimulus
        bit saturated;
        saturated = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            shadow_dev[i]   = '0;
            shadow_blk[i]   = '0;
            shadow_refs[i]  = 0;
            shadow_stamp[i] = '0;
            shadow_valid[i] = 1'b0;
        end

        // Directed: reset tags hit at the lowest index, age ties, extremes,
        // unpin to zero without stamp, underflow on release and unpin.
        add_req(rlbcd_pkg::OP_GET, 16'h0000, 32'h0000_0000, 5'd0, 31'd0, 1'b0);
        add_req(rlbcd_pkg::OP_GET, 16'h0000, 32'h0000_0000, 5'd31, 31'h7FFF_FFFF, 1'b0);
        add_req(rlbcd_pkg::OP_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0, 31'd0, 1'b0);
        add_req(rlbcd_pkg::OP_GET, 16'h1234, 32'h0000_0000, 5'd0, 31'd0, 1'b0);
        add_req(rlbcd_pkg::OP_GET, 16'h0000, 32'hFFFF_FFFF, 5'd0, 31'd0, 1'b0);
        add_req(rlbcd_pkg::OP_PIN, 16'h0000, 32'h0, 5'd31, 31'd0, 1'b0);
        add_req(rlbcd_pkg::OP_UNPIN, 16'h0000, 32'h0, 5'd31, 31'd9, 1'b0);
        add_req(rlbcd_pkg::OP_UNPIN, 16'h0000, 32'h0, 5'd31, 31'd9, 1'b0);
        add_req(rlbcd_pkg::OP_RELEASE, 16'h0000, 32'h0, 5'd30, 31'd1, 1'b0);
        add_req(rlbcd_pkg::OP_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 5'd1, 31'h7FFF_FFFF, 1'b0);
        add_req(rlbcd_pkg::OP_RELEASE, 16'h0000, 32'h0, 5'd2, 31'd0, 1'b0);
        add_req(rlbcd_pkg::OP_RELEASE, 16'h0000, 32'h0, 5'd3, 31'd5, 1'b0);
        add_req(rlbcd_pkg::OP_GET, 16'hABCD, 32'h89AB_CDEF, 5'd0, 31'd0, 1'b0);
        add_req(rlbcd_pkg::OP_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0, 31'd0, 1'b0);
        add_req(rlbcd_pkg::OP_PIN, 16'h0000, 32'h0, 5'd1, 31'd0, 1'b0);
        add_req(rlbcd_pkg::OP_UNPIN, 16'h0000, 32'h0, 5'd1, 31'd0, 1'b0);
        add_req(rlbcd_pkg::OP_RELEASE, 16'h0000, 32'h0, 5'd1, 31'd3, 1'b0);
        add_req(rlbcd_pkg::OP_RELEASE, 16'h0000, 32'h0, 5'd0, 31'h4000_0000, 1'b0);
        add_req(rlbcd_pkg::OP_RELEASE, 16'h0000, 32'h0, 5'd0, 31'h4000_0000, 1'b0);
        add_req(rlbcd_pkg::OP_GET, 16'h5555, 32'hAAAA_AAAA, 5'd0, 31'd0, 1'b0);
        add_req(rlbcd_pkg::OP_GET, 16'h8000, 32'h8000_0000, 5'd0, 31'd0, 1'b0);

        // Random part: open with a full fill, saturate one entry once, then mix.
        fill_and_drain();
        while (generated < RANDOM_ITEMS + 21) begin
            if (!saturated && generated > 500) begin
                saturate_entry();
                saturated = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                fill_and_drain();
            end else begin
                mixed_traffic();
            end
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Hold until all items are taken and every response is back, then settle.
        while (dir_requests.size() > 0 || have_req || awaited_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Driver: change inputs at the falling edge only.
    always @(negedge aclk) begin : driver
        bit nxt_valid;
        nxt_valid = 1'b0;
        if (aresetn) begin
            if (req_taken) begin
                req_taken = 1'b0;
                have_req  = 1'b0;
            end
            // advance to the next item unless it asks to wait for a drained pipe
            if (!have_req && dir_requests.size() > 0 &&
                !(dir_requests[0].drain_first && awaited_results.size() > 0)) begin
                cur_req   = dir_requests.pop_front();
                have_req  = 1'b1;
                req_shown = 1'b0;
                case (cur_req.phase)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                    default: begin send_idle_pct = 18; recv_stall_pct = 18; end
                endcase
            end
            // once shown, hold valid until the item is taken
            if (have_req)
                nxt_valid = req_shown || ($urandom_range(0, 99) >= send_idle_pct);
            req_shown = nxt_valid;
            s_tvalid <= nxt_valid;
            s_tdata  <= {2'b00, cur_req.now_ticks, cur_req.entry_index,
                         cur_req.block_number, cur_req.device, cur_req.op};
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: check responses first, then log accepted items, at the rising edge.
    always @(posedge aclk) begin : monitor
        dir_resp_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("response with nothing awaited: result_entry %0d status %0d",
                           m_tdata[4:0], m_tdata[8:7]);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata[4:0] !== want.entry) begin
                        $error("result_entry expected %0d actual %0d", want.entry, m_tdata[4:0]);
                        mismatches++;
                    end
                    if (m_tdata[5] !== want.hit) begin
                        $error("was_hit expected %0d actual %0d", want.hit, m_tdata[5]);
                        mismatches++;
                    end
                    if (m_tdata[6] !== want.read) begin
                        $error("needs_read expected %0d actual %0d", want.read, m_tdata[6]);
                        mismatches++;
                    end
                    if (m_tdata[8:7] !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, m_tdata[8:7]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(cur_req.resp);
                req_taken = 1'b1;
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
